@@ rtl/stcb_pkg.sv @@
// ----------------------------------------------------------------------------
// stcb_pkg
// Shared types and constants for the timer channel bank.
// ----------------------------------------------------------------------------
package stcb_pkg;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned VAL_W        = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic walk_rd;    // tick walk: read channel at walk index
    logic read_done;  // read data is back, capture into result
    logic tick_done;  // tick walk finished, capture tick count
    logic load_out;   // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } dp_status_t;

endpackage

@@ rtl/software_timer_channel_bank.sv @@
// ----------------------------------------------------------------------------
// software_timer_channel_bank
// Bank of up/down millisecond counter channels with a free-running tick count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   tick, start, stop or read, with channel, direction and interval fields.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   command: tick count for tick, channel value for read, zero otherwise,
//   plus the active/direction flags and a status bit for an ignored start.
// Sequence: start and stop go from acceptance to the output register; a read
//   first captures the registered memory read; a tick first walks every channel.
// Throughput: one command at a time; the next transfer is taken in the cycle
//   after the result moves to the output register. A tick walks the channel
//   memory one channel per cycle (single read port, registered read data).
// Reset: tick count, all channel values and limits read as zero and every
//   channel is inactive, at once (per-entry valid bits, no clearing pass).
// Stall: a result waits in the output register while out_stall_i is high; the
//   block still takes and finishes the next command, holding its result in
//   a staging register until the output register frees up.
// ----------------------------------------------------------------------------
module software_timer_channel_bank
  import stcb_pkg::*;
#(
  parameter int unsigned Channels = CHANNELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic             count_up_i,
  input  logic [VAL_W-1:0] interval_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] value_o,
  output logic             active_o,
  output logic             counting_up_o,
  output logic             status_o
);

  localparam int unsigned IW = (Channels > 1) ? $clog2(Channels) : 1;

  ctrl_cmd_t     ctrl;
  dp_status_t    dp_status;
  logic [IW-1:0] walk_idx;

  // sequencer: owns the handshake on the input side and the tick walk
  stcb_ctrl #(
    .Channels (Channels)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .status_i   (dp_status),
    .ctrl_o     (ctrl),
    .walk_idx_o (walk_idx)
  );

  // storage, channel update and output register
  stcb_datapath #(
    .Channels (Channels)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .walk_idx_i    (walk_idx),
    .status_o      (dp_status),
    .command_i     (command_i),
    .channel_i     (channel_i),
    .count_up_i    (count_up_i),
    .interval_i    (interval_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .active_o      (active_o),
    .counting_up_o (counting_up_o),
    .res_status_o  (status_o)
  );

endmodule

@@ rtl/stcb_datapath.sv @@
// ----------------------------------------------------------------------------
// stcb_datapath
// Channel storage, tick counter, channel update logic and result registers.
// ----------------------------------------------------------------------------
module stcb_datapath
  import stcb_pkg::*;
#(
  parameter int unsigned Channels = CHANNELS_DEF,
  localparam int unsigned IW = (Channels > 1) ? $clog2(Channels) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        ctrl_i,
  input  logic [IW-1:0]    walk_idx_i,
  output dp_status_t       status_o,
  input  logic [CMD_W-1:0] command_i,
  input  logic [CH_W-1:0]  channel_i,
  input  logic             count_up_i,
  input  logic [VAL_W-1:0] interval_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] value_o,
  output logic             active_o,
  output logic             counting_up_o,
  output logic             res_status_o
);

  // channel storage
  logic [VAL_W-1:0] value_mem [Channels];
  logic [VAL_W-1:0] limit_mem [Channels];
  logic [Channels-1:0] value_vld_q, limit_vld_q;
  logic [Channels-1:0] active_q, up_q;

  logic [VAL_W-1:0] tick_count_q;
  logic [VAL_W-1:0] rd_value_q, rd_limit_q;
  logic [IW-1:0]    rd_idx_q;
  logic             rd_ok_q;
  logic             p_vld_q;

  logic [VAL_W-1:0] res_value_q;
  logic             res_active_q, res_up_q, res_status_q;

  logic             out_valid_q;
  logic [VAL_W-1:0] out_value_q;
  logic             out_active_q, out_up_q, out_status_q;

  logic          ch_ok;
  logic [IW-1:0] ch_addr;
  logic [IW-1:0] rd_addr;
  logic          is_start, is_stop, is_tick;
  logic          start_up, start_dn, start_zero, do_stop;

  // tick walk update
  logic [VAL_W-1:0] cur_v, cur_l, inc_v, dec_v;
  logic             p_act, p_up;
  logic             p_wr, p_clr;
  logic [VAL_W-1:0] p_wd;

  // value memory write port
  logic             val_we;
  logic [IW-1:0]    val_wa;
  logic [VAL_W-1:0] val_wd;

  assign ch_ok   = 32'(channel_i) < Channels;
  assign ch_addr = IW'(channel_i);

  assign is_tick  = ctrl_i.accept && (command_i == CMD_TICK);
  assign is_start = ctrl_i.accept && (command_i == CMD_START) && ch_ok;
  assign is_stop  = ctrl_i.accept && (command_i == CMD_STOP);

  assign start_up   = is_start && count_up_i;
  assign start_dn   = is_start && !count_up_i && (interval_i != '0);
  assign start_zero = is_start && !count_up_i && (interval_i == '0);
  assign do_stop    = is_stop && ch_ok;

  assign rd_addr = ctrl_i.walk_rd ? walk_idx_i : ch_addr;

  always_comb begin
    cur_v = value_vld_q[rd_idx_q] ? rd_value_q : '0;
    cur_l = limit_vld_q[rd_idx_q] ? rd_limit_q : '0;
    inc_v = cur_v + VAL_W'(1);
    dec_v = cur_v - VAL_W'(1);
    p_act = p_vld_q && active_q[rd_idx_q];
    p_up  = up_q[rd_idx_q];
    p_wr  = 1'b0;
    p_clr = 1'b0;
    p_wd  = inc_v;
    if (p_act) begin
      if (p_up) begin
        p_wr  = 1'b1;
        p_clr = (cur_l != '0) && (inc_v >= cur_l);
      end else if (cur_v != '0) begin
        p_wr = 1'b1;
        p_wd = dec_v;
      end else begin
        p_clr = 1'b1;
      end
    end
  end

  always_comb begin
    val_we = 1'b0;
    val_wa = ch_addr;
    val_wd = '0;
    if (start_up) begin
      val_we = 1'b1;
    end else if (start_dn) begin
      val_we = 1'b1;
      val_wd = interval_i;
    end else if (p_wr) begin
      val_we = 1'b1;
      val_wa = rd_idx_q;
      val_wd = p_wd;
    end
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[val_wa] <= val_wd;
    end
    if (start_up) begin
      limit_mem[ch_addr] <= interval_i;
    end
    rd_value_q <= value_mem[rd_addr];
    rd_limit_q <= limit_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_vld_q  <= '0;
      limit_vld_q  <= '0;
      active_q     <= '0;
      up_q         <= '0;
      tick_count_q <= '0;
      rd_idx_q     <= '0;
      rd_ok_q      <= 1'b0;
      p_vld_q      <= 1'b0;
    end else begin
      rd_idx_q <= rd_addr;
      rd_ok_q  <= ch_ok;
      p_vld_q  <= ctrl_i.walk_rd;
      if (val_we) begin
        value_vld_q[val_wa] <= 1'b1;
      end
      if (start_up) begin
        limit_vld_q[ch_addr] <= 1'b1;
        active_q[ch_addr]    <= 1'b1;
        up_q[ch_addr]        <= 1'b1;
      end else if (start_dn) begin
        active_q[ch_addr] <= 1'b1;
        up_q[ch_addr]     <= 1'b0;
      end else if (do_stop) begin
        active_q[ch_addr] <= 1'b0;
      end else if (p_clr) begin
        active_q[rd_idx_q] <= 1'b0;
      end
      if (is_tick) begin
        tick_count_q <= tick_count_q + VAL_W'(1);
      end
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      res_value_q  <= '0;
      res_status_q <= start_zero;
      if (is_tick || !ch_ok) begin
        res_active_q <= 1'b0;
        res_up_q     <= 1'b0;
      end else if (start_up) begin
        res_active_q <= 1'b1;
        res_up_q     <= 1'b1;
      end else if (start_dn) begin
        res_active_q <= 1'b1;
        res_up_q     <= 1'b0;
      end else if (do_stop) begin
        res_active_q <= 1'b0;
        res_up_q     <= up_q[ch_addr];
      end else begin
        res_active_q <= active_q[ch_addr];
        res_up_q     <= up_q[ch_addr];
      end
    end else if (ctrl_i.read_done) begin
      res_value_q <= rd_ok_q ? cur_v : '0;
    end else if (ctrl_i.tick_done) begin
      res_value_q <= tick_count_q;
    end
  end

  // output register
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_value_q  <= res_value_q;
      out_active_q <= res_active_q;
      out_up_q     <= res_up_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_value_q;
  assign active_o      = out_active_q;
  assign counting_up_o = out_up_q;
  assign res_status_o  = out_status_q;

endmodule

@@ rtl/stcb_ctrl.sv @@
// ----------------------------------------------------------------------------
// stcb_ctrl
// Command sequencer: accepts items, walks channels on tick, hands off results.
// ----------------------------------------------------------------------------
module stcb_ctrl
  import stcb_pkg::*;
#(
  parameter int unsigned Channels = CHANNELS_DEF,
  localparam int unsigned IW = (Channels > 1) ? $clog2(Channels) : 1,
  localparam int unsigned CW = $clog2(Channels + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] command_i,
  input  dp_status_t       status_i,
  output ctrl_cmd_t        ctrl_o,
  output logic [IW-1:0]    walk_idx_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] walk_q, walk_d;
  logic          walk_more;

  assign walk_more  = walk_q < CW'(Channels);
  assign walk_idx_o = walk_q[IW-1:0];
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    walk_d  = walk_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          walk_d        = '0;
          if (command_i == CMD_TICK) begin
            state_d = S_TICK;
          end else if (command_i == CMD_READ) begin
            state_d = S_READ;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_TICK: begin
        if (walk_more) begin
          ctrl_o.walk_rd = 1'b1;
          walk_d         = walk_q + CW'(1);
        end else begin
          ctrl_o.tick_done = 1'b1;
          state_d          = S_HOLD;
        end
      end
      S_READ: begin
        ctrl_o.read_done = 1'b1;
        state_d          = S_HOLD;
      end
      S_HOLD: begin
        if (status_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

endmodule
